// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEXHI,
    MODE_BSL,
    MODE_U,
    MODE_HEXLO
  } mode_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA = 2'd0;
  localparam kind_t KIND_DONE = 2'd1;
  localparam kind_t KIND_ERR  = 2'd2;

  typedef logic [3:0] err_t;
  localparam err_t ERR_NONE       = 4'd0;
  localparam err_t ERR_NO_QUOTE   = 4'd1;
  localparam err_t ERR_CONTROL    = 4'd2;
  localparam err_t ERR_OPEN_ESC   = 4'd3;
  localparam err_t ERR_SHORT_U    = 4'd4;
  localparam err_t ERR_BAD_HEX    = 4'd5;
  localparam err_t ERR_LONE_HIGH  = 4'd6;
  localparam err_t ERR_BAD_LOW    = 4'd7;
  localparam err_t ERR_LONE_LOW   = 4'd8;
  localparam err_t ERR_BAD_ESC    = 4'd9;
  localparam err_t ERR_UNTERM     = 4'd10;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [15:0] HIGH_LO = 16'hd800;
  localparam logic [15:0] HIGH_HI = 16'hdbff;
  localparam logic [15:0] LOW_LO  = 16'hdc00;
  localparam logic [15:0] LOW_HI  = 16'hdfff;

  // results caused by one accepted item: data bytes first, then an optional terminal
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            has_term;
    kind_t           term_kind;
    err_t            err;
  } bundle_t;

  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) d = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      d = {1'b0, c[3:0] + 4'd9};
    return d;
  endfunction

  // bit 8 set means not a simple escape letter
  function automatic logic [8:0] esc_byte(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h22:   r = {1'b0, 8'h22};
      8'h5c:   r = {1'b0, 8'h5c};
      8'h2f:   r = {1'b0, 8'h2f};
      8'h62:   r = {1'b0, 8'h08};
      8'h66:   r = {1'b0, 8'h0c};
      8'h6e:   r = {1'b0, 8'h0a};
      8'h72:   r = {1'b0, 8'h0d};
      8'h74:   r = {1'b0, 8'h09};
      default: r = 9'h100;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp <= 21'h7f) begin
      u.nbytes   = 3'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      u.nbytes   = 3'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      u.nbytes   = 3'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.nbytes   = 3'd4;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// ===== hdl/jsu_in_if.sv =====
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

// ===== hdl/jsu_out_if.sv =====
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [3:0] err_code;
  logic       out_last;

  modport source (output valid, output out_byte, output out_kind, output err_code,
                  output out_last, input ready);
  modport sink (input valid, input out_byte, input out_kind, input err_code,
                input out_last, output ready);
endinterface

// ===== hdl/jsu_front.sv =====
module jsu_front (
  input  logic             clk,
  input  logic             rst,
  jsu_in_if.sink           text,
  input  logic             full,
  output logic             push,
  output jsu_pkg::bundle_t bundle
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [2:0]  hex_count, hex_count_next;
  logic [9:0]  high_half, high_half_next;
  logic        accept;

  assign text.ready = !full;
  assign accept     = text.valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      hex_accum <= '0;
      hex_count <= '0;
      high_half <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_accum <= hex_accum_next;
      hex_count <= hex_count_next;
      high_half <= high_half_next;
    end
  end

  always_comb begin
    logic [7:0]  c;
    logic        last;
    logic [4:0]  d;
    logic [8:0]  esc;
    logic [15:0] acc;
    logic [2:0]  cnt;
    logic [20:0] cp;
    logic        fail;
    err_t        code;
    utf8_t       u;
    c    = text.in_byte;
    last = text.text_end;
    d    = hex_digit(c);
    esc  = esc_byte(c);
    acc  = {hex_accum[11:0], d[3:0]};
    cnt  = hex_count + 3'd1;
    cp   = {({1'b0, high_half} + 11'h040), acc[9:0]};
    fail = 1'b0;
    code = ERR_NONE;
    u    = '0;

    mode_next      = mode;
    hex_accum_next = hex_accum;
    hex_count_next = hex_count;
    high_half_next = high_half;
    bundle         = '0;

    unique case (mode)
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          bundle.has_term  = 1'b1;
          bundle.term_kind = KIND_DONE;
          mode_next        = MODE_IDLE;
        end else if (c < CH_SPACE) begin
          fail = 1'b1;
          code = ERR_CONTROL;
        end else if (c == CH_BSLASH) begin
          if (last) begin
            fail = 1'b1;
            code = ERR_OPEN_ESC;
          end else begin
            mode_next = MODE_ESC;
          end
        end else begin
          u.nbytes   = 3'd1;
          u.bytes[0] = c;
          fail       = last;
          code       = ERR_UNTERM;
        end
      end
      MODE_ESC: begin
        if (!esc[8]) begin
          u.nbytes   = 3'd1;
          u.bytes[0] = esc[7:0];
          mode_next  = MODE_STR;
          fail       = last;
          code       = ERR_UNTERM;
        end else if (c == CH_U) begin
          if (last) begin
            fail = 1'b1;
            code = ERR_SHORT_U;
          end else begin
            mode_next      = MODE_HEXHI;
            hex_accum_next = '0;
            hex_count_next = '0;
          end
        end else begin
          fail = 1'b1;
          code = ERR_BAD_ESC;
        end
      end
      MODE_HEXHI: begin
        if (d[4]) begin
          fail = 1'b1;
          code = ERR_BAD_HEX;
        end else begin
          hex_accum_next = acc;
          hex_count_next = cnt;
          if (!cnt[2]) begin
            fail = last;
            code = ERR_SHORT_U;
          end else begin
            hex_count_next = '0;
            if (acc >= HIGH_LO && acc <= HIGH_HI) begin
              high_half_next = acc[9:0];
              hex_accum_next = '0;
              mode_next      = MODE_BSL;
              fail           = last;
              code           = ERR_LONE_HIGH;
            end else if (acc >= LOW_LO && acc <= LOW_HI) begin
              fail = 1'b1;
              code = ERR_LONE_LOW;
            end else begin
              u              = utf8_encode({5'd0, acc});
              hex_accum_next = '0;
              mode_next      = MODE_STR;
              fail           = last;
              code           = ERR_UNTERM;
            end
          end
        end
      end
      MODE_BSL: begin
        if (c != CH_BSLASH || last) begin
          fail = 1'b1;
          code = ERR_LONE_HIGH;
        end else begin
          mode_next = MODE_U;
        end
      end
      MODE_U: begin
        if (c != CH_U || last) begin
          fail = 1'b1;
          code = ERR_LONE_HIGH;
        end else begin
          mode_next      = MODE_HEXLO;
          hex_accum_next = '0;
          hex_count_next = '0;
        end
      end
      MODE_HEXLO: begin
        if (d[4]) begin
          fail = 1'b1;
          code = ERR_BAD_LOW;
        end else begin
          hex_accum_next = acc;
          hex_count_next = cnt;
          if (!cnt[2]) begin
            fail = last;
            code = ERR_LONE_HIGH;
          end else if (acc < LOW_LO || acc > LOW_HI) begin
            fail = 1'b1;
            code = ERR_BAD_LOW;
          end else begin
            u              = utf8_encode(cp);
            hex_accum_next = '0;
            hex_count_next = '0;
            high_half_next = '0;
            mode_next      = MODE_STR;
            fail           = last;
            code           = ERR_UNTERM;
          end
        end
      end
      default: begin
        if (c != CH_QUOTE) begin
          fail = 1'b1;
          code = ERR_NO_QUOTE;
        end else if (last) begin
          fail = 1'b1;
          code = ERR_UNTERM;
        end else begin
          mode_next = MODE_STR;
        end
      end
    endcase

    bundle.nbytes = u.nbytes;
    bundle.bytes  = u.bytes;
    if (fail) begin
      bundle.has_term  = 1'b1;
      bundle.term_kind = KIND_ERR;
      bundle.err       = code;
    end
    // any terminal result returns the scanner to its reset state
    if (bundle.has_term) begin
      mode_next      = MODE_IDLE;
      hex_accum_next = '0;
      hex_count_next = '0;
      high_half_next = '0;
    end
    push = accept && (bundle.has_term || (u.nbytes != 3'd0));
  end

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    push && bundle.has_term |=> mode == MODE_IDLE && high_half == '0 && hex_count == '0)
    else $error("scanner not cleared after terminal result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    hex_count <= 3'd4 && ((mode == MODE_BSL || mode == MODE_U) -> hex_count == '0))
    else $error("hex digit count out of range");

endmodule

// ===== hdl/jsu_queue.sv =====
module jsu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsu_pkg::bundle_t wr_bundle,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output jsu_pkg::bundle_t head
);
  import jsu_pkg::*;

  bundle_t    mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/jsu_back.sv =====
module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             not_empty,
  input  jsu_pkg::bundle_t head,
  output logic             pop,
  jsu_out_if.source        result
);
  import jsu_pkg::*;

  logic       ovalid;
  logic [7:0] obyte;
  kind_t      okind;
  err_t       oerr;
  logic       olast;
  logic [2:0] idx;
  logic [2:0] total;
  logic       load;
  logic       is_last;

  assign total   = head.nbytes + {2'b00, head.has_term};
  assign is_last = idx == total - 3'd1;
  assign load    = not_empty && (!ovalid || result.ready);
  assign pop     = load && is_last;

  assign result.valid    = ovalid;
  assign result.out_byte = obyte;
  assign result.out_kind = okind;
  assign result.err_code = oerr;
  assign result.out_last = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (load) ovalid <= 1'b1;
      else if (result.ready) ovalid <= 1'b0;
      // advance within the bundle, drop it after its last result
      if (load) idx <= is_last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      olast <= is_last;
      if (idx < head.nbytes) begin
        obyte <= head.bytes[idx[1:0]];
        okind <= KIND_DATA;
        oerr  <= ERR_NONE;
      end else begin
        obyte <= '0;
        okind <= head.term_kind;
        oerr  <= head.err;
      end
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    not_empty |-> idx < total)
    else $error("result index past end of bundle");

  a_err_only_on_error: assert property (@(posedge clk) disable iff (rst)
    ovalid && okind != KIND_ERR |-> oerr == ERR_NONE)
    else $error("error code on a non-error result");

  a_term_is_last: assert property (@(posedge clk) disable iff (rst)
    ovalid && okind != KIND_DATA |-> olast && obyte == '0)
    else $error("terminal result not last or carries a byte");

endmodule

// ===== hdl/json_string_unescaper.sv =====
// Channel  Dir  Fields                                   Item
// text     in   in_byte[7:0], text_end                   one raw byte of JSON text
// result   out  out_byte[7:0], out_kind[1:0],            one decoded byte, done or error
//               err_code[3:0], out_last
//
// One byte is taken per cycle while the bundle queue is not full. The output
// sequencer presents each result on its own; a byte may yield up to 5 results (a
// \u escape with a trailing error). A two-entry bundle queue between scanner and
// sequencer buffers them against output stalls. Synchronous reset returns the scanner
// to waiting for an opening quote and empties the queue. Either side may stall at any time.
module json_string_unescaper (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    text,
  jsu_out_if.source result
);
  import jsu_pkg::*;

  logic    push, full, pop, not_empty;
  bundle_t wr_bundle, head;

  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .full   (full),
    .push   (push),
    .bundle (wr_bundle)
  );

  jsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (wr_bundle),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .result    (result)
  );

endmodule
